// ===== rtl/bbv_pkg.sv =====
// Bernstein basis vector core: shared types, constants and Q1.15 arithmetic.
// No dependencies; used by bbv_cell and bernstein_basis_vector_core.
package bbv_pkg;

    localparam int          MAX_DEGREE_DEF = 15;
    localparam logic [15:0] ONE_Q15        = 16'h8000;
    localparam logic [31:0] ROUND_HALF     = 32'd16384;

    typedef struct packed {
        logic [3:0]  degree;
        logic [15:0] param_u;
    } bbv_request_t;

    typedef struct packed {
        logic [3:0]  coef_index;
        logic [15:0] coef_value;
        logic        last;
    } bbv_result_t;

    // Row control, same for every cell
    typedef struct packed {
        logic load;
        logic raise;
        logic shift;
    } bbv_ctrl_t;

    // a*b in Q1.15, round to nearest, ties up; a, b <= 1.0
    function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] prod;
        prod = 32'(a) * 32'(b) + ROUND_HALF;
        return prod[30:15];
    endfunction

    function automatic logic [15:0] add_sat(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, ONE_Q15}) ? ONE_Q15 : sum[15:0];
    endfunction

endpackage

// ===== rtl/bbv_cell.sv =====
// One coefficient cell of the basis row: degree raise and shift-out.
// Depends on bbv_pkg.
module bbv_cell (
    input  logic              clk,
    input  bbv_pkg::bbv_ctrl_t ctrl,
    input  logic [15:0]       init_value,
    input  logic [15:0]       u,
    input  logic [15:0]       u1,
    input  logic [15:0]       carry_in,
    input  logic [15:0]       shift_in,
    output logic [15:0]       carry_out,
    output logic [15:0]       coef
);

    logic [15:0] coef_reg;
    logic [15:0] coef_next;

    // carry handed to the next cell up: old coefficient times u
    assign carry_out = bbv_pkg::mul_q15(coef_reg, u);
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (ctrl.load)
        begin
            coef_next = init_value;
        end
        else if (ctrl.raise)
        begin
            coef_next = bbv_pkg::add_sat(carry_in, bbv_pkg::mul_q15(coef_reg, u1));
        end
        else if (ctrl.shift)
        begin
            coef_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

endmodule

// ===== rtl/bernstein_basis_vector_core.sv =====
// Bernstein basis vector core: B(k,n,u), k = 0..n, Q1.15, from a row of cells.
// The first result beat follows the n degree raises, which run one per cycle.
// A new request is taken only in idle; busy covers n raises and n+1 result beats.
// Results leave one beat per cycle from the head cell while the row shifts down.
// The receiver cannot stall. Reset (rst_n, async low) returns the sequencer to idle.
// Depends on bbv_pkg and bbv_cell.
module bernstein_basis_vector_core #(
    parameter int MAX_DEGREE = bbv_pkg::MAX_DEGREE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bbv_pkg::bbv_request_t request,
    output logic                  strobe,
    output bbv_pkg::bbv_result_t  result
);

    localparam logic [3:0] DEG_LIMIT = (MAX_DEGREE > 15) ? 4'd15 : 4'(MAX_DEGREE);
    localparam int         NUM_CELLS = int'(DEG_LIMIT) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RAISE = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  n_reg, n_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] u_reg, u_next;
    logic [15:0] u1_reg, u1_next;

    logic        accept;
    logic [3:0]  deg_clamped;
    logic [15:0] u_clamped;

    bbv_pkg::bbv_ctrl_t ctrl;

    logic [15:0] carry [NUM_CELLS+1];
    logic [15:0] coef  [NUM_CELLS+1];

    assign accept      = start && (state_reg == ST_IDLE);
    assign busy        = (state_reg != ST_IDLE);
    assign deg_clamped = (request.degree > DEG_LIMIT) ? DEG_LIMIT : request.degree;
    assign u_clamped   = (request.param_u > bbv_pkg::ONE_Q15) ? bbv_pkg::ONE_Q15
                                                              : request.param_u;

    assign ctrl.load  = accept;
    assign ctrl.raise = (state_reg == ST_RAISE);
    assign ctrl.shift = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        u1_next    = u1_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = deg_clamped;
                    cnt_next   = 4'd0;
                    u_next     = u_clamped;
                    u1_next    = bbv_pkg::ONE_Q15 - u_clamped;
                    state_next = (deg_clamped == 4'd0) ? ST_EMIT : ST_RAISE;
                end
            end
            ST_RAISE:
            begin
                if (cnt_reg == n_reg - 4'd1)
                begin
                    cnt_next   = 4'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_EMIT:
            begin
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg  <= n_next;
        u_reg  <= u_next;
        u1_reg <= u1_next;
    end

    // Carry runs up the row, shifted data runs down toward the head cell
    assign carry[0]         = 16'd0;
    assign coef[NUM_CELLS]  = 16'd0;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        bbv_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .init_value ((k == 0) ? bbv_pkg::ONE_Q15 : 16'd0),
            .u          (u_reg),
            .u1         (u1_reg),
            .carry_in   (carry[k]),
            .shift_in   (coef[k+1]),
            .carry_out  (carry[k+1]),
            .coef       (coef[k])
        );
    end

    assign strobe            = (state_reg == ST_EMIT);
    assign result.coef_index = cnt_reg;
    assign result.coef_value = coef[0];
    assign result.last      = (cnt_reg == n_reg);

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result beat while not busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !busy)
        else $error("busy held after last beat");

    a_beats_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> (strobe && result.coef_index == $past(result.coef_index) + 4'd1))
        else $error("gap or skip in result beats");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted start did not raise busy");
`endif

endmodule

// ===== dv/testbench.sv =====
// Testbench for bernstein_basis_vector_core: sends degree/parameter requests and checks
// every basis beat against a Q1.15 predictor kept here. Depends on bbv_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int          DEGREE_LIMIT = bbv_pkg::MAX_DEGREE_DEF;
    localparam int unsigned UNITY        = 32'(bbv_pkg::ONE_Q15);
    localparam int          DRAIN_CYCLES = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    bbv_pkg::bbv_request_t request;
    logic                  strobe;
    bbv_pkg::bbv_result_t  result;

    bbv_pkg::bbv_result_t  expected_beats[$];
    int                    error_count;
    bit                    idle_enable;

    bernstein_basis_vector_core #(
        .MAX_DEGREE (DEGREE_LIMIT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    always #5 clk = ~clk;

    // Q1.15 product, round to nearest with ties up
    function automatic int unsigned q15_product(input int unsigned a, input int unsigned b);
        return (a * b + 32'd16384) >> 15;
    endfunction

    function automatic int unsigned q15_sum_sat(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > UNITY) ? UNITY : s;
    endfunction

    // Raise the degree from 1.0 up to n, then queue the n+1 basis beats
    function automatic void queue_basis(input bbv_pkg::bbv_request_t req);
        int                   n;
        int unsigned          u;
        int unsigned          u1;
        int unsigned          carry;
        int unsigned          prev;
        int unsigned          coef[16];
        bbv_pkg::bbv_result_t beat;
        n = int'(req.degree);
        if (n > DEGREE_LIMIT)
            n = DEGREE_LIMIT;
        u = 32'(req.param_u);
        if (u > UNITY)
            u = UNITY;
        u1 = UNITY - u;
        coef[0] = UNITY;
        for (int j = 1; j <= n; j++)
        begin
            carry = 0;
            for (int k = 0; k < j; k++)
            begin
                prev    = coef[k];
                coef[k] = q15_sum_sat(carry, q15_product(prev, u1));
                carry   = q15_product(prev, u);
            end
            coef[j] = carry;
        end
        for (int k = 0; k <= n; k++)
        begin
            beat.coef_index = 4'(k);
            beat.coef_value = 16'(coef[k]);
            beat.last       = (k == n);
            expected_beats  = {expected_beats, beat};
        end
    endfunction

    // Drive one request at the falling edge and hold it until the core drops busy again
    task automatic send_request(input logic [3:0] deg, input logic [15:0] u);
        int gap;
        @(negedge clk);
        if (idle_enable && ($urandom_range(99) < 7))
        begin
            start = 1'b0;
            gap   = $urandom_range(1, 40);
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        start           = 1'b1;
        request.degree  = deg;
        request.param_u = u;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        queue_basis(request);
    endtask

    always @(posedge clk)
    begin
        bbv_pkg::bbv_result_t want;
        if (rst_n && strobe)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: expected none, actual idx %0d val %0d last %0b",
                         $time, result.coef_index, result.coef_value, result.last);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (want.coef_index !== result.coef_index || want.coef_value !== result.coef_value
                    || want.last !== result.last)
                begin
                    $display("%0t: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                             $time, want.coef_index, want.coef_value, want.last,
                             result.coef_index, result.coef_value, result.last);
                    error_count++;
                end
            end
        end
    end

    task automatic test_degree_zero();
        send_request(4'd0, 16'd0);
        send_request(4'd0, 16'h8000);
        send_request(4'd0, 16'hFFFF);
    endtask

    // u at 0, just above 0, 1.0, just around 1.0 and far above it (clamped); two low-degree cases
    task automatic test_param_extremes();
        send_request(4'd15, 16'd0);
        send_request(4'd15, 16'h8000);
        send_request(4'd15, 16'h8001);
        send_request(4'd15, 16'hFFFF);
        send_request(4'd15, 16'h7FFF);
        send_request(4'd15, 16'd1);
        send_request(4'd1, 16'h4000);
        send_request(4'd2, 16'h5555);
    endtask

    task automatic test_degree_sweep();
        for (int d = 1; d <= 15; d++)
            send_request(4'(d), 16'($urandom_range(0, 32768)));
    endtask

    task automatic test_random_mix();
        logic [15:0] u;
        for (int i = 0; i < 250; i++)
        begin
            // a long stretch with back-to-back requests
            idle_enable = !(i >= 100 && i < 170);
            case ($urandom_range(9))
                0:       u = 16'($urandom_range(32769, 65535));
                1:       u = ($urandom_range(1)) ? 16'h8000 : 16'd0;
                2:       u = 16'($urandom_range(0, 8));
                default: u = 16'($urandom_range(0, 32768));
            endcase
            send_request(4'($urandom_range(15)), u);
        end
        idle_enable = 1'b1;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        error_count = 0;
        idle_enable = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_degree_zero();
        test_param_extremes();
        test_degree_sweep();
        test_random_mix();

        @(negedge clk);
        start = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_beats.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
